FILE: rtl/heater_status_packet_decoder_assert.svh
// Assertion macros for the heater status packet decoder.
// Included by the top level; no other dependencies.
`ifndef HEATER_STATUS_PACKET_DECODER_ASSERT_SVH
`define HEATER_STATUS_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hspd_pkg.sv
// Package for the heater status packet decoder: codes, constants, types.
// No dependencies.
package hspd_pkg;

    // Error codes of a result word
    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_SHORT        = 3'd1,
        ERR_HEADER       = 3'd2,
        ERR_TEMP_INVALID = 3'd3,
        ERR_TEMP_INSANE  = 3'd4
    } t_err;

    localparam int unsigned CNT_W = 4;

    // Packet layout
    localparam logic [CNT_W-1:0] PKT_MIN_LEN      = 4'd13;
    localparam logic [CNT_W-1:0] POS_HDR0         = 4'd0;
    localparam logic [CNT_W-1:0] POS_HDR1         = 4'd1;
    localparam logic [CNT_W-1:0] POS_HDR2         = 4'd2;
    localparam logic [CNT_W-1:0] POS_STATUS_FIRST = 4'd3;
    localparam logic [CNT_W-1:0] POS_STATUS_SEC   = 4'd4;
    localparam logic [CNT_W-1:0] POS_WHOLE_DEG    = 4'd5;
    localparam logic [CNT_W-1:0] POS_POWER_HI     = 4'd6;
    localparam logic [CNT_W-1:0] POS_POWER_LO     = 4'd7;
    localparam logic [CNT_W-1:0] POS_TEMP_HI      = 4'd10;
    localparam logic [CNT_W-1:0] POS_TEMP_LO      = 4'd11;

    localparam logic [7:0] HDR_BYTE0 = 8'h5b;
    localparam logic [7:0] HDR_BYTE1 = 8'h03;
    localparam logic [7:0] HDR_BYTE2 = 8'h0e;

    // Raw temperature limits, tenths of a degree Celsius
    localparam logic [15:0] RAW_ABSENT   = 16'hffff;
    localparam logic [15:0] RAW_UNREAD   = 16'hfffe;
    localparam logic [15:0] RAW_TEMP_MAX = 16'd600;
    localparam logic [15:0] RAW_SANE_LO  = 16'd50;
    localparam logic [15:0] RAW_SANE_HI  = 16'd450;

    // Fahrenheit offset in hundredths: 32.00 F
    localparam logic [13:0] F_OFFSET = 14'd3200;

    // Packet state collected so far
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             header_good;
        logic [7:0]       status_first;
        logic [7:0]       status_second;
        logic [7:0]       whole_degree;
        logic [15:0]      power;
        logic [15:0]      temp_tenths;
    } t_held;

    // One decoded result word
    typedef struct packed {
        t_err        error_code;
        logic [7:0]  status_first;
        logic [7:0]  status_second;
        logic [7:0]  whole_degree_byte;
        logic [15:0] power_watts;
        logic        heating_now;
        logic [8:0]  temp_c_tenths;
        logic [13:0] temp_f_hundredths;
    } t_result;

endpackage

FILE: rtl/hspd_ifs.sv
// Valid/ready channel interfaces of the heater status packet decoder.
// Byte channel in, result channel out; no dependencies.
interface hspd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hspd_result_if;
    logic        valid;
    logic        ready;
    logic        decode_ok;
    logic [2:0]  error_code;
    logic [7:0]  status_first;
    logic [7:0]  status_second;
    logic [7:0]  whole_degree_byte;
    logic [15:0] power_watts;
    logic        heating_now;
    logic [8:0]  temp_c_tenths;
    logic [13:0] temp_f_hundredths;

    modport source (output valid, output decode_ok, output error_code,
                    output status_first, output status_second,
                    output whole_degree_byte, output power_watts,
                    output heating_now, output temp_c_tenths,
                    output temp_f_hundredths, input ready);
    modport sink   (input valid, input decode_ok, input error_code,
                    input status_first, input status_second,
                    input whole_degree_byte, input power_watts,
                    input heating_now, input temp_c_tenths,
                    input temp_f_hundredths, output ready);
endinterface

FILE: rtl/hspd_eval.sv
// Result evaluation: error priority, field masking, Celsius to Fahrenheit.
// Depends on hspd_pkg.
module hspd_eval (
    input  hspd_pkg::t_held   i_held,
    output hspd_pkg::t_result o_res
);
    import hspd_pkg::*;

    logic        temp_invalid;
    logic        temp_insane;
    logic [8:0]  raw9;
    logic [13:0] f_hundredths;

    // Range checks on the raw temperature
    assign temp_invalid = (i_held.temp_tenths == RAW_ABSENT)
                       || (i_held.temp_tenths == RAW_UNREAD)
                       || (i_held.temp_tenths > RAW_TEMP_MAX);
    assign temp_insane  = (i_held.temp_tenths < RAW_SANE_LO)
                       || (i_held.temp_tenths > RAW_SANE_HI);

    // raw*18 + 3200 as shift-add; only used when raw <= 450
    assign raw9         = i_held.temp_tenths[8:0];
    assign f_hundredths = {1'b0, raw9, 4'b0000} + {4'b0000, raw9, 1'b0} + F_OFFSET;

    always_comb begin
        o_res = '0;
        priority if (i_held.byte_count < PKT_MIN_LEN) begin
            o_res.error_code = ERR_SHORT;
        end else if (!i_held.header_good) begin
            o_res.error_code = ERR_HEADER;
        end else begin
            o_res.status_first      = i_held.status_first;
            o_res.status_second     = i_held.status_second;
            o_res.whole_degree_byte = i_held.whole_degree;
            o_res.power_watts       = i_held.power;
            o_res.heating_now       = (i_held.power != 16'd0);
            priority if (temp_invalid) begin
                o_res.error_code = ERR_TEMP_INVALID;
            end else if (temp_insane) begin
                o_res.error_code = ERR_TEMP_INSANE;
            end else begin
                o_res.error_code        = ERR_OK;
                o_res.temp_c_tenths     = raw9;
                o_res.temp_f_hundredths = f_hundredths;
            end
        end
    end

endmodule

FILE: rtl/heater_status_packet_decoder.sv
// A result word is registered and valid in the cycle after the last byte is accepted.
// One byte per cycle while the output register is free.
// The single output register frees in the cycle its word is taken, so input
// keeps flowing as long as the result sink takes each word.
// Reset (i_rst_n low, synchronous): byte count cleared, header flag set,
// output register empty. Depends on hspd_pkg, hspd_ifs, hspd_eval.
`include "heater_status_packet_decoder_assert.svh"

module heater_status_packet_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hspd_byte_if.sink     i_pkt,
    hspd_result_if.source o_res
);
    import hspd_pkg::*;

    t_held   r_held;
    t_held   n_held;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_accept;

    // Output register is free when empty or being drained
    assign i_pkt.ready = !r_out_valid || o_res.ready;
    assign in_accept   = i_pkt.valid && i_pkt.ready;

    // Fold the incoming byte into the packet state
    always_comb begin
        n_held = r_held;
        if (r_held.byte_count < PKT_MIN_LEN) begin
            n_held.byte_count = r_held.byte_count + 4'd1;
            unique case (r_held.byte_count)
                POS_HDR0:         if (i_pkt.data_byte != HDR_BYTE0) n_held.header_good = 1'b0;
                POS_HDR1:         if (i_pkt.data_byte != HDR_BYTE1) n_held.header_good = 1'b0;
                POS_HDR2:         if (i_pkt.data_byte != HDR_BYTE2) n_held.header_good = 1'b0;
                POS_STATUS_FIRST: n_held.status_first  = i_pkt.data_byte;
                POS_STATUS_SEC:   n_held.status_second = i_pkt.data_byte;
                POS_WHOLE_DEG:    n_held.whole_degree  = i_pkt.data_byte;
                POS_POWER_HI:     n_held.power[15:8]    = i_pkt.data_byte;
                POS_POWER_LO:     n_held.power[7:0]     = i_pkt.data_byte;
                POS_TEMP_HI:      n_held.temp_tenths[15:8] = i_pkt.data_byte;
                POS_TEMP_LO:      n_held.temp_tenths[7:0]  = i_pkt.data_byte;
                default:          ;
            endcase
        end
    end

    hspd_eval u_eval (
        .i_held (n_held),
        .o_res  (w_res)
    );

    // Packet state; restart after the last byte.
    // Captured fields need no reset: each is rewritten before a full packet uses it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.byte_count  <= '0;
            r_held.header_good <= 1'b1;
        end else if (in_accept) begin
            if (i_pkt.last_byte) begin
                r_held.byte_count  <= '0;
                r_held.header_good <= 1'b1;
            end else begin
                r_held.byte_count  <= n_held.byte_count;
                r_held.header_good <= n_held.header_good;
            end
            r_held.status_first  <= n_held.status_first;
            r_held.status_second <= n_held.status_second;
            r_held.whole_degree  <= n_held.whole_degree;
            r_held.power         <= n_held.power;
            r_held.temp_tenths   <= n_held.temp_tenths;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_pkt.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_pkt.last_byte) begin
            r_res <= w_res;
        end
    end

    // Result word
    assign o_res.valid             = r_out_valid;
    assign o_res.decode_ok         = (r_res.error_code == ERR_OK);
    assign o_res.error_code        = r_res.error_code;
    assign o_res.status_first      = r_res.status_first;
    assign o_res.status_second     = r_res.status_second;
    assign o_res.whole_degree_byte = r_res.whole_degree_byte;
    assign o_res.power_watts       = r_res.power_watts;
    assign o_res.heating_now       = r_res.heating_now;
    assign o_res.temp_c_tenths     = r_res.temp_c_tenths;
    assign o_res.temp_f_hundredths = r_res.temp_f_hundredths;

    // Checks
    `HSPD_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, in_accept && i_pkt.last_byte,
        r_out_valid && (r_held.byte_count == '0) && r_held.header_good,
        "last byte did not load a result and restart the packet")
    `HSPD_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n,
        in_accept && !i_pkt.last_byte && (r_held.byte_count < PKT_MIN_LEN),
        r_held.byte_count == ($past(r_held.byte_count) + 4'd1),
        "byte count did not advance on an accepted byte")
    `HSPD_ASSERT_IMPL(a_ok_temp_range, i_clk, i_rst_n, r_out_valid && (r_res.error_code == ERR_OK),
        (r_res.temp_c_tenths >= 9'd50) && (r_res.temp_c_tenths <= 9'd450),
        "ok result with temperature out of range")
    `HSPD_ASSERT_IMPL(a_early_err_zero, i_clk, i_rst_n,
        r_out_valid && ((r_res.error_code == ERR_SHORT) || (r_res.error_code == ERR_HEADER)),
        (r_res.power_watts == 16'd0) && !r_res.heating_now && (r_res.status_first == 8'd0),
        "short or bad-header result carries nonzero fields")

endmodule

FILE: verif/tb_heater_status_packet_decoder.sv
// Testbench for heater_status_packet_decoder: directed packets from a table, then random packets,
// every result word checked field by field against a hand-written result or a decoder model here.
// Depends on hspd_pkg, hspd_ifs and the decoder RTL.
module tb_heater_status_packet_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import hspd_pkg::*;

    // One packet to send: layout fields, plus a hand-written result where it is obvious
    typedef struct packed {
        logic [4:0]  len;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [7:0]  sf;
        logic [7:0]  ss;
        logic [7:0]  wd;
        logic [15:0] pwr;
        logic [15:0] raw;
        logic        typed;
        t_result     want;
    } t_pkt_row;

    localparam t_result NO_WANT = '0;
    localparam int      N_DIRECTED = 16;
    localparam int      N_RANDOM = 110;

    logic clk = 1'b0;
    logic rst_n;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hspd_byte_if   pkt_if();
    hspd_result_if res_if();

    heater_status_packet_decoder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if)
    );

    // Decoder model state: what has been gathered of the current packet
    logic [CNT_W-1:0] seen_count;
    logic             hdr_intact;
    logic [7:0]       cap_sf;
    logic [7:0]       cap_ss;
    logic [7:0]       cap_wd;
    logic [15:0]      cap_power;
    logic [15:0]      cap_raw;

    t_result   pending_words[$];
    int        mismatches = 0;
    bit        steady = 1'b0;
    t_pkt_row  pkt_table [N_DIRECTED];
    logic [15:0] raw_edges [8] = '{16'd49, 16'd50, 16'd450, 16'd451,
                                   16'd600, 16'd601, 16'hfffe, 16'hffff};

    function automatic void clear_capture();
        seen_count = '0;
        hdr_intact = 1'b1;
        cap_sf     = '0;
        cap_ss     = '0;
        cap_wd     = '0;
        cap_power  = '0;
        cap_raw    = '0;
    endfunction

    // Absorb one accepted byte; returns 1 with the decoded word when it closes a packet
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_result r);
        logic [31:0] f_wide;
        r = '0;
        if (seen_count < PKT_MIN_LEN) begin
            case (seen_count)
                POS_HDR0:         if (b != HDR_BYTE0) hdr_intact = 1'b0;
                POS_HDR1:         if (b != HDR_BYTE1) hdr_intact = 1'b0;
                POS_HDR2:         if (b != HDR_BYTE2) hdr_intact = 1'b0;
                POS_STATUS_FIRST: cap_sf = b;
                POS_STATUS_SEC:   cap_ss = b;
                POS_WHOLE_DEG:    cap_wd = b;
                POS_POWER_HI:     cap_power[15:8] = b;
                POS_POWER_LO:     cap_power[7:0] = b;
                POS_TEMP_HI:      cap_raw[15:8] = b;
                POS_TEMP_LO:      cap_raw[7:0] = b;
                default: ;
            endcase
            seen_count = seen_count + 1'b1;
        end
        if (!last) return 1'b0;

        if (seen_count < PKT_MIN_LEN) begin
            r.error_code = ERR_SHORT;
        end else if (!hdr_intact) begin
            r.error_code = ERR_HEADER;
        end else begin
            r.status_first      = cap_sf;
            r.status_second     = cap_ss;
            r.whole_degree_byte = cap_wd;
            r.power_watts       = cap_power;
            r.heating_now       = (cap_power != 16'd0);
            if (cap_raw == RAW_ABSENT || cap_raw == RAW_UNREAD || cap_raw > RAW_TEMP_MAX) begin
                r.error_code = ERR_TEMP_INVALID;
            end else if (cap_raw < RAW_SANE_LO || cap_raw > RAW_SANE_HI) begin
                r.error_code = ERR_TEMP_INSANE;
            end else begin
                r.error_code        = ERR_OK;
                r.temp_c_tenths     = cap_raw[8:0];
                f_wide              = 32'(cap_raw) * 32'd18 + 32'(F_OFFSET);
                r.temp_f_hundredths = f_wide[13:0];
            end
        end
        clear_capture();
        return 1'b1;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one byte at the falling edge, hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_result want);
        t_result r;
        while (!steady && $urandom_range(99) < 19) begin
            pkt_if.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= b;
        pkt_if.last_byte <= last;
        @(posedge clk);
        while (!pkt_if.ready) @(posedge clk);
        if (decode_byte(b, last, r)) pending_words.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic send_packet(input t_pkt_row p);
        logic [7:0]       b;
        logic [CNT_W-1:0] pos;
        for (int i = 0; i < p.len; i++) begin
            pos = CNT_W'(i);
            case (pos)
                POS_HDR0:         b = p.h0;
                POS_HDR1:         b = p.h1;
                POS_HDR2:         b = p.h2;
                POS_STATUS_FIRST: b = p.sf;
                POS_STATUS_SEC:   b = p.ss;
                POS_WHOLE_DEG:    b = p.wd;
                POS_POWER_HI:     b = p.pwr[15:8];
                POS_POWER_LO:     b = p.pwr[7:0];
                POS_TEMP_HI:      b = p.raw[15:8];
                POS_TEMP_LO:      b = p.raw[7:0];
                default:          b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == p.len - 1, p.typed, p.want);
        end
    endtask

    // Result sink: random back-pressure, none during the steady stretch
    always @(negedge clk) begin
        res_if.ready <= steady || ($urandom_range(99) >= 19);
    end

    // Check each taken result word against the oldest expectation
    always @(posedge clk) begin : watch_results
        t_result want;
        if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
            if (pending_words.size() == 0) begin
                report("word with nothing pending, error_code", res_if.error_code, 0);
            end else begin
                want = pending_words.pop_front();
                if (res_if.decode_ok !== (want.error_code == ERR_OK))
                    report("decode_ok", res_if.decode_ok, want.error_code == ERR_OK);
                if (res_if.error_code !== want.error_code)
                    report("error_code", res_if.error_code, want.error_code);
                if (res_if.status_first !== want.status_first)
                    report("status_first", res_if.status_first, want.status_first);
                if (res_if.status_second !== want.status_second)
                    report("status_second", res_if.status_second, want.status_second);
                if (res_if.whole_degree_byte !== want.whole_degree_byte)
                    report("whole_degree_byte", res_if.whole_degree_byte,
                           want.whole_degree_byte);
                if (res_if.power_watts !== want.power_watts)
                    report("power_watts", res_if.power_watts, want.power_watts);
                if (res_if.heating_now !== want.heating_now)
                    report("heating_now", res_if.heating_now, want.heating_now);
                if (res_if.temp_c_tenths !== want.temp_c_tenths)
                    report("temp_c_tenths", res_if.temp_c_tenths, want.temp_c_tenths);
                if (res_if.temp_f_hundredths !== want.temp_f_hundredths)
                    report("temp_f_hundredths", res_if.temp_f_hundredths,
                           want.temp_f_hundredths);
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        t_pkt_row row;

        rst_n            = 1'b0;
        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = 8'h00;
        pkt_if.last_byte = 1'b0;
        clear_capture();

        // Directed packets: short, bad header, temperature edges, overlong
        pkt_table = '{
            '{5'd1,  8'h5b, 8'h03, 8'h0e, 8'h00, 8'h00, 8'h00, 16'h0000, 16'd200, 1'b1,
              '{ERR_SHORT, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 9'd0, 14'd0}},
            '{5'd12, 8'h5b, 8'h03, 8'h0e, 8'h12, 8'h34, 8'h19, 16'h00ff, 16'd200, 1'b1,
              '{ERR_SHORT, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 9'd0, 14'd0}},
            '{5'd13, 8'h00, 8'h03, 8'h0e, 8'h12, 8'h34, 8'h19, 16'h00ff, 16'd200, 1'b1,
              '{ERR_HEADER, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 9'd0, 14'd0}},
            '{5'd13, 8'h5b, 8'hff, 8'h0e, 8'hff, 8'hff, 8'hff, 16'hffff, 16'd200, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0f, 8'h01, 8'h02, 8'h03, 16'h0001, 16'd200, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h00, 8'hff, 8'h00, 16'hffff, 16'd50, 1'b1,
              '{ERR_OK, 8'h00, 8'hff, 8'h00, 16'hffff, 1'b1, 9'd50, 14'd4100}},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'hff, 8'h00, 8'hff, 16'h0000, 16'd450, 1'b1,
              '{ERR_OK, 8'hff, 8'h00, 8'hff, 16'h0000, 1'b0, 9'd450, 14'd11300}},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h5a, 8'ha5, 8'h1c, 16'h8000, 16'hffff, 1'b1,
              '{ERR_TEMP_INVALID, 8'h5a, 8'ha5, 8'h1c, 16'h8000, 1'b1, 9'd0, 14'd0}},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h11, 8'h22, 8'h33, 16'h0100, 16'hfffe, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h44, 8'h55, 8'h66, 16'h00c8, 16'd601, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h77, 8'h88, 8'h99, 16'h0000, 16'd600, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'haa, 8'hbb, 8'hcc, 16'h7fff, 16'd49, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'hdd, 8'hee, 8'h2d, 16'h0002, 16'd451, 1'b0,
              NO_WANT},
            '{5'd13, 8'h5b, 8'h03, 8'h0e, 8'h01, 8'h80, 8'h00, 16'hfffe, 16'd0, 1'b0,
              NO_WANT},
            '{5'd16, 8'h5b, 8'h03, 8'h0e, 8'h3c, 8'hc3, 8'h14, 16'h04b0, 16'd200, 1'b0,
              NO_WANT},
            '{5'd5,  8'h00, 8'h00, 8'h00, 8'h3c, 8'hc3, 8'h14, 16'h04b0, 16'd200, 1'b1,
              '{ERR_SHORT, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 9'd0, 14'd0}}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_packet(pkt_table[k]);
            // Hold the input off once until every pending word is out
            if (k == 7) begin
                pkt_if.valid <= 1'b0;
                @(negedge clk);
                while (pending_words.size() != 0) @(negedge clk);
            end
        end

        // Random packets: mostly well formed, some short, some overlong, some with a bad header
        for (int n = 0; n < N_RANDOM; n++) begin
            steady    = (n >= 40 && n < 60);
            row.len   = 5'd13;
            row.h0    = HDR_BYTE0;
            row.h1    = HDR_BYTE1;
            row.h2    = HDR_BYTE2;
            row.sf    = 8'($urandom_range(255));
            row.ss    = 8'($urandom_range(255));
            row.wd    = 8'($urandom_range(255));
            row.pwr   = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom_range(65535));
            row.typed = 1'b0;
            row.want  = NO_WANT;
            case ($urandom_range(9))
                0: row.len = 5'($urandom_range(1, 12));
                1: begin
                    case ($urandom_range(2))
                        0: row.h0 = 8'($urandom_range(255));
                        1: row.h1 = 8'($urandom_range(255));
                        default: row.h2 = 8'($urandom_range(255));
                    endcase
                end
                2: row.len = 5'($urandom_range(14, 16));
                default: ;
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4: row.raw = 16'($urandom_range(50, 450));
                5:             row.raw = raw_edges[$urandom_range(7)];
                6:             row.raw = 16'($urandom_range(451, 600));
                7:             row.raw = 16'($urandom_range(0, 49));
                8:             row.raw = 16'($urandom_range(65535));
                default:       row.raw = 16'($urandom_range(601, 65533));
            endcase
            send_packet(row);
        end
        steady = 1'b0;

        // Drain and finish
        pkt_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: heater_status_packet_decoder.f
+incdir+rtl
rtl/hspd_pkg.sv
rtl/hspd_ifs.sv
rtl/hspd_eval.sv
rtl/heater_status_packet_decoder.sv
verif/tb_heater_status_packet_decoder.sv
